FILE: rtl/phep_pkg.sv
// Shared types, constants and helper functions for the pH-from-potential pipeline.
// No dependencies; every other file of the block imports this package.
package phep_pkg;

    localparam int LOGISTIC_TABLE_DEPTH_DEF = 256;
    localparam int TC_BITS = 17;

    localparam longint Q30 = 64'sd1073741824;
    localparam longint EINV_Q30 = 64'sd395007542;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SCAN  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    // Potentials and limits are Q16 millivolts.
    typedef struct packed {
        logic                 ok;
        logic signed [27:0]   peak;
        logic signed [27:0]   refp;
        logic [15:0]          den;
        logic signed [27:0]   lo;
        logic signed [27:0]   hi;
        logic [TC_BITS-1:0]   tc;
    } item_t;

    // Divide by 2^16, rounding to nearest with ties away from zero.
    function automatic logic signed [63:0] rnd_q16(input logic signed [63:0] n);
        logic signed [63:0] m;
        begin
            if (n < 0) begin
                m = -n;
                rnd_q16 = -((m + 64'sd32768) >>> 16);
            end else begin
                rnd_q16 = (n + 64'sd32768) >>> 16;
            end
        end
    endfunction

    // e^-k in Q30 for a whole number k, capped at 40.
    function automatic longint einv_pow(input longint k);
        longint p, n, lim;
        begin
            p = Q30;
            lim = (k > 40) ? 40 : k;
            for (n = 0; n < lim; n++)
                p = (p * EINV_Q30 + (Q30 >>> 1)) >>> 30;
            einv_pow = p;
        end
    endfunction

endpackage

FILE: rtl/ph_from_electrode_potential_core.sv
// Top level of the pH-from-electrode-potential pipeline: ports, input skid stage, mode register.
// Depends on phep_pkg, phep_limits, phep_div and phep_eval.
//
// Each request on the s_ channel carries a peak potential, a reference potential and a
// water temperature in s_tdata and the scan-check bit in s_tuser. Each request yields one
// result on the m_ channel: the pH in 1/4096 units in m_tdata and a status code in m_tuser.
// The ocean_mode register is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while the pipeline is empty, as the block itself does not enforce this.
// The pipeline holds one input stage, four stages for the clamp limits, 17 stages in the
// divider that forms the temperature factor, eight evaluation stages and the output
// register. Throughput is one request per cycle while m_tready is high.
// All stages advance together whenever the output register is empty or being taken. When
// m_tready is low, one more request is still taken into a skid register and s_tready then
// drops until the pipeline moves again; nothing is dropped or repeated.
// Synchronous reset clears all valid bits and sets ocean_mode to freshwater.
module ph_from_electrode_potential_core
    import phep_pkg::*;
#(
    parameter int LOGISTIC_TABLE_DEPTH = LOGISTIC_TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_wr_data,   // ocean_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,       // peak_potential, reference_potential, water_temp
    input  logic [0:0]  s_tuser,       // flags_ok
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // ph_value
    output logic [1:0]  m_tuser        // status
);

    logic        ocean_mode_reg;
    logic        skid_valid_reg;
    logic [47:0] skid_data_reg;
    logic        skid_ok_reg;
    logic        v0_reg;
    item_t       it0_reg;
    logic        en;
    logic [47:0] sel_data;
    logic        sel_ok;
    logic signed [16:0] den_s;
    item_t       it0_next;
    logic        lim_valid, div_valid;
    item_t       lim_item, div_item;
    status_t     status;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = !skid_valid_reg;

    always_comb begin
        sel_data = skid_valid_reg ? skid_data_reg : s_tdata;
        sel_ok   = skid_valid_reg ? skid_ok_reg : s_tuser[0];
        den_s    = 17'($signed(sel_data[45:32])) + 17'sd27300;
        it0_next      = '0;
        it0_next.ok   = sel_ok;
        it0_next.peak = $signed({sel_data[15:0], 12'b0});
        it0_next.refp = $signed({sel_data[31:16], 12'b0});
        it0_next.den  = 16'(den_s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ocean_mode_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
            v0_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ocean_mode_reg <= cfg_wr_data[0];
            end
            if (en) begin
                skid_valid_reg <= 1'b0;
                v0_reg         <= skid_valid_reg || s_tvalid;
            end else if (s_tvalid && s_tready) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_tvalid && s_tready) begin
            skid_data_reg <= s_tdata;
            skid_ok_reg   <= s_tuser[0];
        end
        if (en) begin
            it0_reg <= it0_next;
        end
    end

    phep_limits u_limits (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v0_reg),
        .in_item   (it0_reg),
        .out_valid (lim_valid),
        .out_item  (lim_item)
    );

    phep_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (lim_valid),
        .in_item   (lim_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    phep_eval #(
        .DEPTH (LOGISTIC_TABLE_DEPTH)
    ) u_eval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .ocean_mode (ocean_mode_reg),
        .in_valid   (div_valid),
        .in_item    (div_item),
        .out_valid  (m_tvalid),
        .out_ph     (m_tdata),
        .out_status (status)
    );

    assign m_tuser = status;

`ifndef SYNTHESIS
    a_skid_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !en |=> skid_valid_reg)
        else $error("skid request lost while stalled");

    a_zero_on_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_OK |-> m_tdata == 16'd0)
        else $error("nonzero pH with fault status");

    a_ph_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= 16'd57344)
        else $error("pH above 14");
`endif

endmodule

FILE: rtl/phep_limits.sv
// Temperature-scaled clamp limits for the reference potential, four pipeline stages.
// Depends on phep_pkg; division by 745 is done with exact reciprocal multiplies.
module phep_limits
    import phep_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    localparam logic [24:0] RECIP_P = 25'd23060228;
    localparam logic [23:0] RECIP_C = 24'd11530114;
    localparam logic [23:0] DIV_K = 24'd745;
    localparam logic [29:0] OFS_800 = 30'd52428800;

    logic [8:0] coef [2];
    assign coef[0] = 9'd311;
    assign coef[1] = 9'd354;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    item_t       it1_reg, it2_reg, it3_reg, it4_reg;
    logic [23:0] p1_reg [2];
    logic [23:0] p2_reg [2];
    logic [14:0] q2_reg [2];
    logic [14:0] q3_reg [2];
    logic [22:0] c3_reg [2];
    logic signed [27:0] lim4_reg [2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it1_reg <= in_item;
            it2_reg <= it1_reg;
            it3_reg <= it2_reg;
            it4_reg <= it3_reg;
        end
    end

    for (genvar k = 0; k < 2; k++) begin : g_lim
        logic [48:0] prod_p;
        logic [46:0] prod_c;
        logic [23:0] rem_p;
        logic [29:0] sum_l;

        assign prod_p = 49'(p1_reg[k]) * 49'(RECIP_P);
        assign rem_p  = p2_reg[k] - 24'(q2_reg[k] * DIV_K);
        assign prod_c = 47'(c3_reg[k]) * 47'(RECIP_C);
        assign sum_l  = 30'({q3_reg[k], 13'b0}) + 30'(prod_c[46:33]) - OFS_800;

        always_ff @(posedge aclk) begin
            if (en) begin
                p1_reg[k]   <= 24'(in_item.den) * 24'(coef[k]);
                p2_reg[k]   <= p1_reg[k];
                q2_reg[k]   <= prod_p[48:34];
                c3_reg[k]   <= {rem_p[9:0], 13'b0} + 23'd372;
                q3_reg[k]   <= q2_reg[k];
                lim4_reg[k] <= 28'(sum_l);
            end
        end
    end

    always_comb begin
        out_item    = it4_reg;
        out_item.lo = lim4_reg[0];
        out_item.hi = lim4_reg[1];
    end
    assign out_valid = v4_reg;

endmodule

FILE: rtl/phep_div.sv
// Pipelined restoring divider for the temperature factor 298/(T+273) in Q16.
// Depends on phep_pkg; one quotient bit per stage, TC_BITS stages.
module phep_div
    import phep_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    localparam int LAST = TC_BITS - 1;
    localparam logic [30:0] NUM_TC = 31'd1952972800;

    logic               v_reg   [TC_BITS];
    item_t              it_reg  [TC_BITS];
    logic [15:0]        rem_reg [TC_BITS];
    logic [TC_BITS-1:0] lq_reg  [TC_BITS];
    logic [30:0]        nd;

    assign nd = NUM_TC + 31'(in_item.den >> 1);

    for (genvar j = 0; j < TC_BITS; j++) begin : g_stage
        logic               v_in;
        item_t              it_in;
        logic [15:0]        rem_in;
        logic [TC_BITS-1:0] lq_in;
        logic [16:0]        trial;
        logic               ge;

        if (j == 0) begin : g_first
            assign v_in   = in_valid;
            assign it_in  = in_item;
            assign rem_in = 16'(nd[30:TC_BITS]);
            assign lq_in  = nd[TC_BITS-1:0];
        end else begin : g_next
            assign v_in   = v_reg[j-1];
            assign it_in  = it_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign lq_in  = lq_reg[j-1];
        end

        assign trial = {rem_in, lq_in[TC_BITS-1]};
        assign ge    = trial >= {1'b0, it_in.den};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                it_reg[j]  <= it_in;
                rem_reg[j] <= ge ? 16'(trial - {1'b0, it_in.den}) : 16'(trial);
                lq_reg[j]  <= {lq_in[TC_BITS-2:0], ge};
            end
        end
    end

    always_comb begin
        out_item    = it_reg[LAST];
        out_item.tc = lq_reg[LAST];
    end
    assign out_valid = v_reg[LAST];

endmodule

FILE: rtl/phep_eval.sv
// Freshwater logistic and seawater cubic evaluation, eight stages plus the output register.
// Depends on phep_pkg for item_t, status codes, rounding and the logistic table entries.
module phep_eval
    import phep_pkg::*;
#(
    parameter int DEPTH = LOGISTIC_TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        ocean_mode,
    input  logic        in_valid,
    input  item_t       in_item,
    output logic        out_valid,
    output logic [15:0] out_ph,
    output status_t     out_status
);

    localparam int IW = $clog2(DEPTH);
    localparam int XW = 25 + IW;
    localparam int TW = XW - 19;

    localparam logic signed [27:0] C705 = 28'sd46202880;
    localparam logic signed [27:0] C720 = 28'sd47185920;
    localparam logic signed [27:0] C905 = 28'sd59310080;
    localparam logic signed [27:0] C920 = 28'sd60293120;
    localparam logic signed [29:0] C530 = 30'sd34734080;
    localparam logic signed [29:0] C805 = 30'sd52756480;
    localparam logic signed [28:0] C500 = 29'sd32768000;
    localparam logic signed [33:0] PH_MAX = 34'sd917504;

    logic [15:0] fac_rom [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        localparam longint U = -28 * Q30 + (40 * Q30 * g + (DEPTH - 1) / 2) / (DEPTH - 1);
        localparam longint V = (U >= 0) ? U : -U;
        localparam longint K = V >>> 30;
        localparam longint R = V - K * Q30;
        localparam longint T1 = (Q30 * R + Q30 * 1 / 2) / (Q30 * 1);
        localparam longint T2 = (T1 * R + Q30 * 2 / 2) / (Q30 * 2);
        localparam longint T3 = (T2 * R + Q30 * 3 / 2) / (Q30 * 3);
        localparam longint T4 = (T3 * R + Q30 * 4 / 2) / (Q30 * 4);
        localparam longint T5 = (T4 * R + Q30 * 5 / 2) / (Q30 * 5);
        localparam longint T6 = (T5 * R + Q30 * 6 / 2) / (Q30 * 6);
        localparam longint T7 = (T6 * R + Q30 * 7 / 2) / (Q30 * 7);
        localparam longint T8 = (T7 * R + Q30 * 8 / 2) / (Q30 * 8);
        localparam longint T9 = (T8 * R + Q30 * 9 / 2) / (Q30 * 9);
        localparam longint T10 = (T9 * R + Q30 * 10 / 2) / (Q30 * 10);
        localparam longint T11 = (T10 * R + Q30 * 11 / 2) / (Q30 * 11);
        localparam longint T12 = (T11 * R + Q30 * 12 / 2) / (Q30 * 12);
        localparam longint SUM = Q30 - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10
                                 - T11 + T12;
        localparam longint P = (einv_pow(K) * SUM + Q30 / 2) / Q30;
        localparam longint S = (U >= 0) ? (Q30 * Q30 + (Q30 + P) / 2) / (Q30 + P)
                                        : (P * Q30 + (Q30 + P) / 2) / (Q30 + P);
        localparam longint W = (77 * Q30 + 3 * S + 64'sd819200) / 64'sd1638400;
        localparam logic [15:0] ENTRY = 16'(W);
        assign fac_rom[g] = ENTRY;
    end

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, vo_reg;
    logic ok1_reg, ok2_reg, ok3_reg, ok4_reg, ok5_reg, ok6_reg, ok7_reg, ok8_reg;
    logic [TC_BITS-1:0] tc1_reg, tc2_reg, tc3_reg, tc4_reg, tc5_reg, tc6_reg, tc7_reg;
    logic signed [27:0] pk1_reg, pk2_reg, pk3_reg, pk4_reg;
    logic signed [27:0] uf1_reg, uf2_reg, uf3_reg, uf4_reg;
    logic signed [28:0] d1_reg;
    logic [XW-1:0]      xi2_reg;
    logic signed [46:0] pd2_reg;
    logic [IW-1:0]      idx3_reg;
    logic [28:0]        to3_reg;
    logic               ng3_reg;
    logic [15:0]        f4_reg;
    logic signed [23:0] x4_reg, x5_reg, x6_reg;
    logic signed [41:0] prod5_reg;
    logic signed [25:0] fk5_reg;
    logic signed [28:0] pk5_reg;
    logic signed [19:0] y1_5_reg;
    logic [28:0]        t6_reg;
    logic               ng6_reg;
    logic signed [25:0] y2_6_reg;
    logic signed [23:0] g7_reg;
    logic signed [49:0] y2x7_reg;
    logic signed [41:0] php8_reg;
    logic signed [33:0] y3_8_reg;
    logic [15:0]        ph_reg;
    status_t            st_reg;

    logic signed [27:0] ref_a, ref_b, used_o;
    logic signed [29:0] d_sum;
    logic [23:0]        v_ofs;
    logic [TW-1:0]      t_idx;
    logic [31:0]        t_mul;
    logic [11:0]        q_idx;
    logic [46:0]        pd_mag, pd_add;
    logic [58:0]        x_mul;
    logic [23:0]        x_mag;
    logic signed [24:0] d905;
    logic signed [29:0] s_sum;
    logic signed [35:0] s18, s18_mag;
    logic [35:0]        a18;
    logic [58:0]        g_mul;
    logic [23:0]        g_mag;
    logic signed [33:0] ph_fin;

    always_comb begin
        ref_a = (in_item.refp < in_item.lo) ? in_item.lo :
                (in_item.refp > in_item.hi) ? in_item.hi : in_item.refp;
        ref_b = (ref_a < C720) ? C720 : (ref_a > C920) ? C920 : ref_a;
        used_o = (in_item.refp < C705) ? C705 :
                 (in_item.refp > C920) ? C920 : in_item.refp;
        d_sum = C530 - 30'(in_item.peak) + C805 - 30'(used_o);

        v_ofs = 24'(uf1_reg - C720);
        t_idx = xi2_reg[XW-1:19];
        t_mul = 32'(t_idx) * 32'd41944;
        q_idx = t_mul[31:20];
        pd_mag = (pd2_reg < 0) ? 47'(-pd2_reg) : 47'(pd2_reg);
        pd_add = pd_mag + 47'd1802240;

        x_mul = 59'(to3_reg) * 59'd624722516;
        x_mag = x_mul[58:35];

        d905 = 25'(uf4_reg - C905);

        s_sum = 30'(pk5_reg) + 30'(rnd_q16(64'(prod5_reg))) + 30'(fk5_reg);
        s18 = 36'(s_sum) * 36'sd18;
        s18_mag = (s18 < 0) ? -s18 : s18;
        a18 = 36'(s18_mag) + 36'd500;

        g_mul = 59'(t6_reg) * 59'd549755814;
        g_mag = 24'(g_mul[58:36]);

        ph_fin = ocean_mode ? y3_8_reg : 34'(rnd_q16(64'(php8_reg)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            vo_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ok1_reg <= in_item.ok;
            tc1_reg <= in_item.tc;
            pk1_reg <= in_item.peak;
            uf1_reg <= ref_b;
            d1_reg  <= 29'(d_sum);

            ok2_reg <= ok1_reg;
            tc2_reg <= tc1_reg;
            pk2_reg <= pk1_reg;
            uf2_reg <= uf1_reg;
            xi2_reg <= XW'(v_ofs) * XW'(DEPTH - 1) + XW'(6553600);
            pd2_reg <= $signed({1'b0, tc1_reg}) * d1_reg;

            ok3_reg  <= ok2_reg;
            tc3_reg  <= tc2_reg;
            pk3_reg  <= pk2_reg;
            uf3_reg  <= uf2_reg;
            idx3_reg <= (q_idx > 12'(DEPTH - 1)) ? IW'(DEPTH - 1) : IW'(q_idx);
            to3_reg  <= pd_add[44:16];
            ng3_reg  <= pd2_reg < 0;

            ok4_reg <= ok3_reg;
            tc4_reg <= tc3_reg;
            pk4_reg <= pk3_reg;
            uf4_reg <= uf3_reg;
            f4_reg  <= fac_rom[idx3_reg];
            x4_reg  <= ng3_reg ? -$signed(x_mag) : $signed(x_mag);

            ok5_reg   <= ok4_reg;
            tc5_reg   <= tc4_reg;
            prod5_reg <= $signed({1'b0, f4_reg}) * d905;
            fk5_reg   <= 26'(32'(f4_reg) * 32'd1000 - 32'd50462720);
            pk5_reg   <= 29'(pk4_reg) - C500;
            y1_5_reg  <= 20'(rnd_q16(64'(36'sd3152 * 36'(x4_reg))) - 64'sd67699);
            x5_reg    <= x4_reg;

            ok6_reg  <= ok5_reg;
            tc6_reg  <= tc5_reg;
            t6_reg   <= a18[31:3];
            ng6_reg  <= s_sum > 0;
            y2_6_reg <= 26'(rnd_q16(64'(y1_5_reg) * 64'(x5_reg)) + 64'sd533312);
            x6_reg   <= x5_reg;

            ok7_reg  <= ok6_reg;
            tc7_reg  <= tc6_reg;
            g7_reg   <= ng6_reg ? -$signed(g_mag) : $signed(g_mag);
            y2x7_reg <= 50'(y2_6_reg) * 50'(x6_reg);

            ok8_reg  <= ok7_reg;
            php8_reg <= 42'($signed({1'b0, tc7_reg}) * g7_reg);
            y3_8_reg <= 34'(rnd_q16(64'(y2x7_reg)) - 64'sd1020920);

            if (!ok8_reg) begin
                st_reg <= STATUS_SCAN;
                ph_reg <= '0;
            end else if (ph_fin < 0 || ph_fin > PH_MAX) begin
                st_reg <= STATUS_RANGE;
                ph_reg <= '0;
            end else begin
                st_reg <= STATUS_OK;
                ph_reg <= 16'((ph_fin + 34'sd8) >>> 4);
            end
        end
    end

    assign out_valid  = vo_reg;
    assign out_ph     = ph_reg;
    assign out_status = st_reg;

endmodule
